// File: src/key_stash_sync_table_unit_macros.svh
// assertion macros for the key stash sync table unit
// used by the port checker only
`ifndef KEY_STASH_SYNC_TABLE_UNIT_MACROS_SVH
`define KEY_STASH_SYNC_TABLE_UNIT_MACROS_SVH
// implication checked every clock outside reset
`define KSST_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define KSST_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// File: src/kss_pkg.sv
// types and command codes for the key stash sync table unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package kss_pkg;
  localparam logic [2:0] CMD_PUSH       = 3'd0;
  localparam logic [2:0] CMD_TICK       = 3'd1;
  localparam logic [2:0] CMD_PURGE      = 3'd2;
  localparam logic [2:0] CMD_PEER_CLEAR = 3'd3;
  localparam logic [2:0] CMD_PEER_ADD   = 3'd4;
  localparam logic [2:0] CMD_CHOOSE     = 3'd5;
  localparam logic [2:0] CMD_REMOVE     = 3'd6;
  localparam logic [2:0] CMD_UNUSED     = 3'd7;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] key_id;
  } kss_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] result_id;
    logic        overflow;
    logic [6:0]  purged_count;
    logic [6:0]  own_count;
    logic [6:0]  peer_count;
  } kss_out_t;

  // per-cycle control broadcast from the sequencer to every cell
  typedef struct packed {
    logic        rot;      // rotate chain by one position
    logic        drop;     // drop the head entry instead of re-appending it
    logic        load;     // append a new entry at the fill position
    logic        clear;    // clear all valid bits
    logic [31:0] new_id;
    logic [31:0] new_stamp;
  } kss_ctl_t;

  function automatic logic [6:0] kss_sat7(input logic [31:0] v);
    return (v > 32'd127) ? 7'd127 : v[6:0];
  endfunction
endpackage
`default_nettype wire

// File: src/kss_cell.sv
// one cell of a rotating chain: id, stamp and valid bit
// depends on kss_pkg
`timescale 1ns / 1ps
`default_nettype none
module kss_cell
  import kss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire kss_ctl_t    ctl,
  input  wire logic        is_tail,   // last live position, takes the head
  input  wire logic        is_fill,   // this cell is first free position
  input  wire logic        prev_v,
  input  wire logic [31:0] prev_id,
  input  wire logic [31:0] prev_stamp,
  input  wire logic        head_v,
  input  wire logic [31:0] head_id,
  input  wire logic [31:0] head_stamp,
  output logic             v_r,
  output logic [31:0]      id_r,
  output logic [31:0]      stamp_r
);
  // valid bit; chain shifts toward index 0, last live cell refilled by head
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      v_r <= 1'b0;
    end else if (ctl.rot) begin
      v_r <= is_tail ? (head_v && !ctl.drop) : prev_v;
    end else if (ctl.load && is_fill) begin
      v_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.rot) begin
      id_r    <= is_tail ? head_id : prev_id;
      stamp_r <= is_tail ? head_stamp : prev_stamp;
    end else if (ctl.load && is_fill) begin
      id_r    <= ctl.new_id;
      stamp_r <= ctl.new_stamp;
    end
  end
endmodule
`default_nettype wire

// File: src/kss_chain.sv
// chain of cells holding one ordered table, rotated one step per cycle while rot is set
// depends on kss_pkg and kss_cell
`timescale 1ns / 1ps
`default_nettype none
module kss_chain
  import kss_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire kss_ctl_t      ctl,
  input  wire logic [CW-1:0] fill,
  output logic               head_v,
  output logic [31:0]        head_id,
  output logic [31:0]        head_stamp
);
  logic [DEPTH:0]       v;
  logic [DEPTH:0][31:0] id;
  logic [DEPTH:0][31:0] st;

  // empty position past the last cell
  assign v[DEPTH]  = 1'b0;
  assign id[DEPTH] = '0;
  assign st[DEPTH] = '0;

  // cell i takes cell i+1; the last live cell takes the head (rotation)
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    kss_cell u_cell (
      .clk, .rst_n, .ctl,
      .is_tail    (fill == CW'(i + 1)),
      .is_fill    (fill == CW'(i)),
      .prev_v     (v[i + 1]),
      .prev_id    (id[i + 1]),
      .prev_stamp (st[i + 1]),
      .head_v     (v[0]),
      .head_id    (id[0]),
      .head_stamp (st[0]),
      .v_r        (v[i]),
      .id_r       (id[i]),
      .stamp_r    (st[i])
    );
  end

  assign head_v     = v[0];
  assign head_id    = id[0];
  assign head_stamp = st[0];
endmodule
`default_nettype wire

// File: src/key_stash_sync_table_unit.sv
// key stash sync table unit: top level, sequencer and result register
// depends on kss_pkg, kss_chain
//
//  channel | ports                        | handshake
//  in      | in_valid in_stall in_data    | accepted on valid && !stall
//  out     | out_valid out_stall out_data | taken on valid && !stall
//  cfg     | cfg_valid cfg_ready cfg_data | written on valid && ready
//
// push, tick, peer_clear, peer_add and unused codes: go straight to the done state.
// purge turns the live own entries once; remove then turns
// the peer list too. choose checks each own entry against
// a peer turn, rotating the peer list until a match or its end.
// reset empties both tables, time zero, ttl 10. one transaction at a time;
// a stalled result holds the block until taken.
`timescale 1ns / 1ps
`default_nettype none
module key_stash_sync_table_unit
  import kss_pkg::*;
#(
  parameter int OWN_DEPTH  = 64,
  parameter int PEER_DEPTH = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire kss_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output kss_out_t      out_data,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic [15:0] cfg_data
);
  localparam int OW = $clog2(OWN_DEPTH + 1);
  localparam int PW = $clog2(PEER_DEPTH + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_OWN   = 3'd1; // purge / remove own turn
  localparam logic [2:0] ST_PEER  = 3'd2; // remove peer turn
  localparam logic [2:0] ST_CHO   = 3'd3; // choose: peer turn for head
  localparam logic [2:0] ST_CHOAD = 3'd4; // choose: advance own
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    cmd_r;
  logic [31:0]   key_r;
  logic [15:0]   ttl_r;
  logic [31:0]   now_r;
  logic [OW-1:0] own_fill_r;
  logic [PW-1:0] peer_fill_r;
  logic [OW-1:0] oi_r;     // own steps done in this turn
  logic [PW-1:0] pi_r;     // peer steps done in this turn
  logic [OW-1:0] olen_r;   // own entries at start of transaction
  logic [PW-1:0] plen_r;   // peer entries at start of transaction
  logic [OW-1:0] purged_r;
  logic          hit_r;    // first match seen in current turn
  logic          found_r, ovf_r;
  logic [31:0]   res_r;
  logic          ov_r;
  kss_out_t      od_r;

  kss_ctl_t own_ctl, peer_ctl;
  logic own_hv, peer_hv;
  logic [31:0] own_hid, own_hst, peer_hid, peer_hst;

  kss_chain #(.DEPTH(OWN_DEPTH)) u_own (
    .clk, .rst_n, .ctl(own_ctl), .fill(own_fill_r),
    .head_v(own_hv), .head_id(own_hid), .head_stamp(own_hst));
  kss_chain #(.DEPTH(PEER_DEPTH)) u_peer (
    .clk, .rst_n, .ctl(peer_ctl), .fill(peer_fill_r),
    .head_v(peer_hv), .head_id(peer_hid), .head_stamp(peer_hst));

  wire idle = (state_r == ST_IDLE) && !ov_r;
  wire in_acc = in_valid && idle;
  assign in_stall  = !idle;
  assign cfg_ready = 1'b1;

  wire [31:0] age      = now_r - own_hst;
  wire        own_end  = oi_r == olen_r;
  wire        peer_end = pi_r == plen_r;
  wire        own_del  = cmd_r == CMD_PURGE ? (own_hv && age > {16'd0, ttl_r})
                                            : (own_hv && !hit_r && own_hid == key_r);
  wire        peer_del = peer_hv && !hit_r && peer_hid == key_r;

  // chain control
  always_comb begin
    own_ctl  = '0;
    peer_ctl = '0;
    own_ctl.new_id    = in_data.key_id;
    own_ctl.new_stamp = now_r;
    peer_ctl.new_id   = in_data.key_id;
    peer_ctl.new_stamp = 32'd0;
    if (in_acc) begin
      own_ctl.load  = in_data.command == CMD_PUSH && own_fill_r != OW'(OWN_DEPTH);
      peer_ctl.load = in_data.command == CMD_PEER_ADD && peer_fill_r != PW'(PEER_DEPTH);
      peer_ctl.clear = in_data.command == CMD_PEER_CLEAR;
    end
    unique case (state_r)
      ST_OWN:   if (!own_end) begin own_ctl.rot = 1'b1; own_ctl.drop = own_del; end
      ST_PEER:  if (!peer_end) begin peer_ctl.rot = 1'b1; peer_ctl.drop = peer_del; end
      ST_CHO:   if (!own_end && !found_r && !peer_end) peer_ctl.rot = 1'b1;
      ST_CHOAD: own_ctl.rot = 1'b1;
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) begin
        if (in_data.command == CMD_PURGE || in_data.command == CMD_REMOVE)
          state_nxt = ST_OWN;
        else if (in_data.command == CMD_CHOOSE)
          state_nxt = ST_CHO;
        else
          state_nxt = ST_DONE;
      end
      ST_OWN:   if (own_end) state_nxt = (cmd_r == CMD_REMOVE) ? ST_PEER : ST_DONE;
      ST_PEER:  if (peer_end) state_nxt = ST_DONE;
      ST_CHO:   if (own_end) state_nxt = ST_DONE;
                else if (found_r || peer_end) state_nxt = ST_CHOAD;
      ST_CHOAD: state_nxt = ST_CHO;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state, time, occupancy and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ttl_r <= 16'd10;
      now_r <= '0;
      own_fill_r <= '0;
      peer_fill_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) ttl_r <= cfg_data;
      if (in_acc && in_data.command == CMD_TICK) now_r <= now_r + 32'd1;
      if (own_ctl.load) own_fill_r <= own_fill_r + OW'(1);
      else if (own_ctl.rot && own_ctl.drop) own_fill_r <= own_fill_r - OW'(1);
      if (peer_ctl.clear) peer_fill_r <= '0;
      else if (peer_ctl.load) peer_fill_r <= peer_fill_r + PW'(1);
      else if (peer_ctl.rot && peer_ctl.drop) peer_fill_r <= peer_fill_r - PW'(1);
      if (state_r == ST_DONE) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  // datapath counters and flags
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_data.command;
      key_r <= in_data.key_id;
      oi_r <= '0; pi_r <= '0; purged_r <= '0;
      olen_r <= own_fill_r; plen_r <= peer_fill_r;
      hit_r <= 1'b0; found_r <= 1'b0; res_r <= '0;
      ovf_r <= (in_data.command == CMD_PUSH && own_fill_r == OW'(OWN_DEPTH)) ||
               (in_data.command == CMD_PEER_ADD && peer_fill_r == PW'(PEER_DEPTH));
    end else begin
      unique case (state_r)
        ST_OWN: if (!own_end) begin
          oi_r <= oi_r + OW'(1);
          if (own_del) begin
            hit_r <= 1'b1;
            if (cmd_r == CMD_REMOVE) found_r <= 1'b1;
            purged_r <= purged_r + OW'(1);
          end
        end else hit_r <= 1'b0;
        ST_PEER: if (!peer_end) begin
          pi_r <= pi_r + PW'(1);
          if (peer_del) hit_r <= 1'b1;
        end
        ST_CHO: if (!own_end && !found_r && !peer_end) begin
          pi_r <= pi_r + PW'(1);
          if (own_hv && peer_hv && peer_hid == own_hid) begin
            found_r <= 1'b1;
            res_r <= own_hid;
          end
        end
        ST_CHOAD: begin
          // next own entry, fresh peer turn
          oi_r <= oi_r + OW'(1);
          pi_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE) begin
      od_r.found        <= found_r;
      od_r.result_id    <= found_r ? res_r : 32'd0;
      od_r.overflow     <= ovf_r;
      od_r.purged_count <= cmd_r == CMD_PURGE ? kss_sat7(32'(purged_r)) : 7'd0;
      od_r.own_count    <= kss_sat7(32'(own_fill_r));
      od_r.peer_count   <= kss_sat7(32'(peer_fill_r));
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule
`default_nettype wire

// File: src/kss_checker.sv
// port checker for the key stash sync table unit, bound to the top level
// depends on kss_pkg and the macros header
`timescale 1ns / 1ps
`default_nettype none
`include "key_stash_sync_table_unit_macros.svh"
module kss_checker
  import kss_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire kss_out_t out_data
);
  // a transaction is accepted only when no result is pending
  `KSST_ASSERT_IMP(a_one_at_a_time, clk, rst_n, out_valid, in_stall)
  // stalled result holds
  `KSST_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  // result id only when found
  `KSST_ASSERT_IMP(a_res_found, clk, rst_n, out_valid && !out_data.found,
                   out_data.result_id == 32'd0)
  // occupancy never exceeds range, and found and overflow are never both set
  `KSST_ASSERT_IMP(a_count, clk, rst_n, out_valid,
                   out_data.own_count <= 7'd127 && !(out_data.found && out_data.overflow))
endmodule

bind key_stash_sync_table_unit kss_checker u_kss_checker (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_data);
`default_nettype wire
